/* hdl/ifa_pkg.sv */
// shared types, codes and helpers for the integer to ascii formatter
package ifa_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned PAD_W    = 6;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned MAX_DIG  = 10;
    localparam int unsigned NDIG_W   = 4;

    localparam logic [PAD_W-1:0]   MAX_PAD   = 6'd62;
    localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int unsigned        RECIP_SH  = 35;

    localparam logic [KIND_W-1:0] KIND_SDEC  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_UDEC  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HEXL  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HEXU  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PTR   = 3'd4;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_SIGN,
        ST_ZERO,
        ST_X,
        ST_PAD,
        ST_DIG
    } state_t;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_MINUS,
        SEL_ZERO,
        SEL_X,
        SEL_PAD,
        SEL_DIG
    } char_sel_t;

    typedef struct packed {
        logic      load;
        logic      step;
        logic      prep;
        logic      pad_dec;
        logic      dig_dec;
        char_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic neg;
        logic ptr;
        logic pad_zero;
        logic pad_one;
        logic dig_zero;
    } status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] base;
        begin
            base = upper ? CH_UP_A : CH_LOW_A;
            if (d < DIGIT_W'(10))
                digit_char = CH_ZERO + CHAR_W'(d);
            else
                digit_char = base + CHAR_W'(d) - CHAR_W'(10);
        end
    endfunction

endpackage

/* hdl/ifa_ctrl.sv */
// controller state machine for the formatter
module ifa_ctrl
    import ifa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_fire;

    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        cmd.sel     = SEL_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.step = 1'b1;
                if (status.conv_done)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
                if (status.neg)
                    state_next = ST_SIGN;
                else if (status.ptr)
                    state_next = ST_ZERO;
                else if (!status.pad_zero)
                    state_next = ST_PAD;
                else
                    state_next = ST_DIG;
            end
            ST_SIGN:
            begin
                out_valid = 1'b1;
                cmd.sel   = SEL_MINUS;
                if (out_fire)
                    state_next = status.pad_zero ? ST_DIG : ST_PAD;
            end
            ST_ZERO:
            begin
                out_valid = 1'b1;
                cmd.sel   = SEL_ZERO;
                if (out_fire)
                    state_next = ST_X;
            end
            ST_X:
            begin
                out_valid = 1'b1;
                cmd.sel   = SEL_X;
                if (out_fire)
                    state_next = status.pad_zero ? ST_DIG : ST_PAD;
            end
            ST_PAD:
            begin
                out_valid = 1'b1;
                cmd.sel   = SEL_PAD;
                if (out_fire)
                begin
                    cmd.pad_dec = 1'b1;
                    if (status.pad_one)
                        state_next = ST_DIG;
                end
            end
            ST_DIG:
            begin
                out_valid = 1'b1;
                cmd.sel   = SEL_DIG;
                if (out_fire)
                begin
                    cmd.dig_dec = 1'b1;
                    if (status.dig_zero)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/ifa_dpath.sv */
// datapath: operand decode, digit extraction, digit store and character select
module ifa_dpath
    import ifa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [VALUE_W-1:0]  value,
    input  logic [KIND_W-1:0]   kind,
    input  logic [PAD_W-1:0]    pad_width,
    input  logic                zero_fill,
    input  cmd_t                cmd,
    output status_t             status,
    output logic [CHAR_W-1:0]   out_char,
    output logic                last
);

    logic [VALUE_W-1:0]     val_reg;
    logic                   hex_reg;
    logic                   upper_reg;
    logic                   neg_reg;
    logic                   ptr_reg;
    logic                   zf_reg;
    logic [PAD_W-1:0]       width_reg;
    logic [NDIG_W-1:0]      nd_reg;
    logic [PAD_W-1:0]       pad_reg;
    logic [NDIG_W-1:0]      idx_reg;
    logic [DIGIT_W-1:0]     digit_reg [MAX_DIG];

    logic                   neg_next;
    logic [VALUE_W-1:0]     mag_next;
    logic [2*VALUE_W-1:0]   prod;
    logic [VALUE_W-1:0]     quot;
    logic [VALUE_W-1:0]     rem_full;
    logic [DIGIT_W-1:0]     dig_next;
    logic [VALUE_W-1:0]     val_next;
    logic [PAD_W-1:0]       pad_next;

    // operand decode
    assign neg_next = (kind == KIND_SDEC) && value[VALUE_W-1];
    assign mag_next = neg_next ? (VALUE_W'(0) - value) : value;

    // one digit per step: divide by ten through the reciprocal, or shift out a nibble for hex
    assign prod     = val_reg * RECIP_TEN;
    assign quot     = VALUE_W'(prod >> RECIP_SH);
    assign rem_full = val_reg - ((quot << 3) + (quot << 1));

    always_comb
    begin
        if (hex_reg)
        begin
            dig_next = val_reg[DIGIT_W-1:0];
            val_next = val_reg >> DIGIT_W;
        end
        else
        begin
            dig_next = rem_full[DIGIT_W-1:0];
            val_next = quot;
        end
    end

    assign pad_next = (width_reg > PAD_W'(nd_reg)) ? (width_reg - PAD_W'(nd_reg)) : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg   <= mag_next;
            neg_reg   <= neg_next;
            hex_reg   <= (kind == KIND_HEXL) || (kind == KIND_HEXU) || (kind == KIND_PTR);
            upper_reg <= (kind == KIND_HEXU) || (kind == KIND_PTR);
            ptr_reg   <= (kind == KIND_PTR);
            zf_reg    <= zero_fill;
            width_reg <= (pad_width > MAX_PAD) ? MAX_PAD : pad_width;
        end
        else if (cmd.step)
        begin
            val_reg           <= val_next;
            digit_reg[nd_reg] <= dig_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nd_reg  <= '0;
            pad_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.load)
                nd_reg <= '0;
            else if (cmd.step)
                nd_reg <= nd_reg + NDIG_W'(1);

            if (cmd.prep)
            begin
                pad_reg <= pad_next;
                idx_reg <= nd_reg - NDIG_W'(1);
            end
            else
            begin
                if (cmd.pad_dec)
                    pad_reg <= pad_reg - PAD_W'(1);
                if (cmd.dig_dec)
                    idx_reg <= idx_reg - NDIG_W'(1);
            end
        end
    end

    assign status.conv_done = (val_next == '0) || (nd_reg == NDIG_W'(MAX_DIG - 1));
    assign status.neg       = neg_reg;
    assign status.ptr       = ptr_reg;
    // during setup the fill count is still being loaded
    assign status.pad_zero  = cmd.prep ? (pad_next == '0) : (pad_reg == '0);
    assign status.pad_one   = (pad_reg == PAD_W'(1));
    assign status.dig_zero  = (idx_reg == '0);

    always_comb
    begin
        case (cmd.sel)
            SEL_MINUS: out_char = CH_MINUS;
            SEL_ZERO:  out_char = CH_ZERO;
            SEL_X:     out_char = CH_X;
            SEL_PAD:   out_char = zf_reg ? CH_ZERO : CH_SPACE;
            SEL_DIG:   out_char = digit_char(digit_reg[idx_reg], upper_reg);
            default:   out_char = '0;
        endcase
    end

    assign last = (cmd.sel == SEL_DIG) && (idx_reg == '0);

endmodule

/* hdl/integer_to_ascii_formatter.sv */
// top level of the integer to ascii formatter
//
// takes one 32-bit value with a conversion kind (signed decimal, unsigned
// decimal, lower hex, upper hex, pointer), a minimum digit width and a fill
// choice, and sends the formatted number out as ascii characters, one per
// output beat, with last high on the final character. a negative signed value
// gets '-' ahead of its fill and digits, a pointer gets "0x" ahead of upper
// hex digits; neither counts toward the width. widths above 62 are held at 62.
// kinds 5 to 7 format as unsigned decimal. one item is handled at a time: after the
// input beat, digit extraction yields one digit per cycle (up to ten for decimal,
// eight for hex) through a single reciprocal multiplier for decimal and shifts for
// hex, a setup state follows, and then the output carries one character per cycle
// while out_ready is high.
module integer_to_ascii_formatter
    import ifa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [VALUE_W-1:0]  value,
    input  logic [KIND_W-1:0]   kind,
    input  logic [PAD_W-1:0]    pad_width,
    input  logic                zero_fill,
    // output channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CHAR_W-1:0]   out_char,
    output logic                last
);

    // command and status between the controller and the datapath
    cmd_t    cmd;
    status_t status;

    // sequencing: accept, digit loop, setup, then sign/prefix, fill and digits
    ifa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // operand decode, digit store and character generation
    ifa_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .kind      (kind),
        .pad_width (pad_width),
        .zero_fill (zero_fill),
        .cmd       (cmd),
        .status    (status),
        .out_char  (out_char),
        .last      (last)
    );

endmodule
